### rtl/core/window_sum_at_most_count_top_macros.svh
// assertion macros shared by the window sum checker
`ifndef WINDOW_SUM_AT_MOST_COUNT_TOP_MACROS_SVH
`define WINDOW_SUM_AT_MOST_COUNT_TOP_MACROS_SVH

// same-cycle implication
`define WSAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WSAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/wsac_pkg.sv
// ----------------------------------------------------------------------------
// wsac_pkg
// Types and constants for the window sum counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsac_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int POS_W     = $clog2(MAX_LEN + 1);
    localparam int VAL_W     = 16;
    localparam int SUM_W     = VAL_W + POS_W;
    localparam int LIMIT_W   = 48;
    localparam int TOT_W     = 20;
    localparam int OUT_POS_W = 11;

    typedef struct packed {
        logic             start_new;
        logic [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [OUT_POS_W-1:0] ending_here;
        logic [TOT_W-1:0]     running_total;
        logic [OUT_POS_W-1:0] window_start;
        logic                 overflow;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHRINK,
        ST_HOLD
    } t_state;

endpackage

### rtl/core/window_sum_at_most_count_top.sv
// ----------------------------------------------------------------------------
// window_sum_at_most_count_top
// Counts contiguous runs with sum at most a limit, using a two-pointer window.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry t_in {start_new, value}.
// Output channel: o_out_valid / i_out_stall carry t_out, one result per item.
// Configuration: i_cfg_we writes i_cfg_data into the 48-bit sum limit.
//
// On accept, an item writes the element store and adds its value; then
// each following cycle drops one element from the window using the store
// read issued the cycle before, and once nothing more is dropped the
// result is formed. An item past the sequence length only reports
// overflow. Every element is dropped at most once per sequence, and the
// input stalls until an item is done. The result goes to the output
// register when that register is free.
//
// The next item is accepted while a result still waits in the output
// register; if the receiver keeps stalling, a finished result parks in a hold
// register and the input stalls until the output register frees up.
// Reset clears the limit, the sequence state and the output valid; the
// element store is not cleared, since only positions written earlier in the
// same sequence are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_sum_at_most_count_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  wsac_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output wsac_pkg::t_out                o_out_data,
    input  logic                          i_cfg_we,
    input  logic [wsac_pkg::LIMIT_W-1:0]  i_cfg_data
);
    import wsac_pkg::*;

    t_state               r_state, n_state;
    logic [LIMIT_W-1:0]   r_limit;
    logic [POS_W-1:0]     r_wp, n_wp;
    logic [POS_W-1:0]     r_left, n_left;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [TOT_W-1:0]     r_total, n_total;
    logic [ADDR_W-1:0]    r_pos, n_pos;
    logic [VAL_W-1:0]     r_value, n_value;
    t_out                 r_out, r_res;
    logic                 r_out_valid;

    logic [VAL_W-1:0]     r_mem [MAX_LEN];
    logic [VAL_W-1:0]     r_rdata;
    logic                 mem_we;
    logic [ADDR_W-1:0]    rd_addr;

    logic                 accept;
    logic                 out_free;
    logic                 res_valid;
    t_out                 res;
    logic [POS_W-1:0]     b_wp, b_left;
    logic [SUM_W-1:0]     b_sum;
    logic [TOT_W-1:0]     b_total;
    logic [POS_W-1:0]     pos_ext;
    logic [POS_W-1:0]     ending;
    logic [VAL_W-1:0]     drop_val;
    logic                 over_limit;
    logic                 do_drop;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign pos_ext  = POS_W'(r_pos);

    // data for r_left was read last cycle; the current element may not be in it yet
    assign drop_val   = (r_left == pos_ext) ? r_value : r_rdata;
    assign over_limit = LIMIT_W'(r_sum) > r_limit;
    assign do_drop    = over_limit && (r_left <= pos_ext);
    assign ending     = pos_ext + POS_W'(1) - r_left;

    assign b_wp    = i_in_data.start_new ? '0 : r_wp;
    assign b_left  = i_in_data.start_new ? '0 : r_left;
    assign b_sum   = i_in_data.start_new ? '0 : r_sum;
    assign b_total = i_in_data.start_new ? '0 : r_total;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (b_wp == POS_W'(MAX_LEN)) begin
                        n_state = out_free ? ST_IDLE : ST_HOLD;
                    end else begin
                        n_state = ST_SHRINK;
                    end
                end
            end
            ST_SHRINK: begin
                if (!do_drop) begin
                    n_state = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_wp      = r_wp;
        n_left    = r_left;
        n_sum     = r_sum;
        n_total   = r_total;
        n_pos     = r_pos;
        n_value   = r_value;
        mem_we    = 1'b0;
        res_valid = 1'b0;
        res       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (b_wp == POS_W'(MAX_LEN)) begin
                        res_valid         = 1'b1;
                        res.running_total = r_total;
                        res.window_start  = OUT_POS_W'(r_left);
                        res.overflow      = 1'b1;
                    end else begin
                        mem_we  = 1'b1;
                        n_pos   = b_wp[ADDR_W-1:0];
                        n_value = i_in_data.value;
                        n_wp    = b_wp + POS_W'(1);
                        n_left  = b_left;
                        n_sum   = b_sum + SUM_W'(i_in_data.value);
                        n_total = b_total;
                    end
                end
            end
            ST_SHRINK: begin
                if (do_drop) begin
                    n_sum  = r_sum - SUM_W'(drop_val);
                    n_left = r_left + POS_W'(1);
                end else begin
                    n_total           = r_total + TOT_W'(ending);
                    res_valid         = 1'b1;
                    res.ending_here   = OUT_POS_W'(ending);
                    res.running_total = n_total;
                    res.window_start  = OUT_POS_W'(r_left);
                    res.overflow      = 1'b0;
                end
            end
            ST_HOLD: begin
                res = r_res;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    assign rd_addr = n_left[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[n_pos] <= n_value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= '0;
            r_wp        <= '0;
            r_left      <= '0;
            r_sum       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_left  <= n_left;
            r_sum   <= n_sum;
            r_total <= n_total;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if ((res_valid || r_state == ST_HOLD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_value <= n_value;
        if ((res_valid || r_state == ST_HOLD) && out_free) begin
            r_out <= res;
        end
        if (res_valid && !out_free) begin
            r_res <= res;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/core/wsac_checker.sv
// ----------------------------------------------------------------------------
// wsac_checker
// Port-level checks for the window sum counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "window_sum_at_most_count_top_macros.svh"

module wsac_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            o_in_stall,
    input  wsac_pkg::t_in   i_in_data,
    input  logic            o_out_valid,
    input  logic            i_out_stall,
    input  wsac_pkg::t_out  o_out_data
);
    import wsac_pkg::*;

    logic [OUT_POS_W:0] span;
    logic               in_xfer;

    assign span    = {1'b0, o_out_data.ending_here} + {1'b0, o_out_data.window_start};
    assign in_xfer = i_in_valid && !o_in_stall;

    // a stalled result stays put
    `WSAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data), "result changed while stalled")

    `WSAC_ASSERT_NOW(a_ovf_zero, i_clk, i_rst_n, o_out_valid && o_out_data.overflow,
        o_out_data.ending_here == '0, "overflow result counts runs")

    // runs ending here never reach past the maximum sequence length
    `WSAC_ASSERT_NOW(a_span, i_clk, i_rst_n, o_out_valid && !o_out_data.overflow,
        span <= (OUT_POS_W+1)'(MAX_LEN), "window reaches past sequence end")

    // the total always includes the runs ending here
    `WSAC_ASSERT_NOW(a_total, i_clk, i_rst_n, o_out_valid && !o_out_data.overflow,
        TOT_W'(o_out_data.ending_here) <= o_out_data.running_total,
        "total below runs ending here")

    // a new sequence always stores its first element, so the input is busy next
    `WSAC_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, in_xfer && i_in_data.start_new,
        o_in_stall, "input not busy after a new sequence transfer")

endmodule

bind window_sum_at_most_count_top wsac_checker u_wsac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
